### src/brl_pkg.sv
// Shared types, constants and helpers for the Bresenham line rasteriser.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

  // Coordinate width, fixed by the item fields
  localparam int COORD_BITS  = 10;
  // Decision term: holds values in the range -2*major .. 2*minor, plus headroom
  localparam int ERR_W       = COORD_BITS + 3;
  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Action codes of an input beat
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // Direction of one axis
  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_INC,
    DIR_DEC
  } dir_t;

  typedef struct packed {
    logic   action;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic   is_load;
    coord_t start_x;
    coord_t start_y;
    coord_t major_len;
    dir_t   dir_x;
    dir_t   dir_y;
    logic   swapped;
    err_t   err_init;
    err_t   inc_minor;   // 2*minor, added when only the major axis steps
    err_t   inc_diag;    // 2*minor - 2*major, added on a diagonal step
  } cmd_t;

  // Move one coordinate a single unit, wrapping at the coordinate width
  function automatic coord_t advance(coord_t c, dir_t d);
    unique case (d)
      DIR_INC: return c + coord_t'(1);
      DIR_DEC: return c - coord_t'(1);
      default: return c;
    endcase
  endfunction

endpackage

`default_nettype wire

### src/brl_front.sv
// Front end: takes input beats, forms deltas, then classifies the line
// (octant, major axis, initial decision term) into a queue command. Uses brl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire brl_pkg::in_item_t in_item,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output brl_pkg::cmd_t          push_cmd
);
  import brl_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic                 fs_valid_r;
  logic                 fs_action_r;
  coord_t               fs_x_r;
  coord_t               fs_y_r;
  logic signed [DW-1:0] fs_dx_r;
  logic signed [DW-1:0] fs_dy_r;

  logic signed [DW-1:0] dx_nxt;
  logic signed [DW-1:0] dy_nxt;
  logic        [DW-1:0] adx_w;
  logic        [DW-1:0] ady_w;
  coord_t               adx;
  coord_t               ady;
  coord_t               major;
  coord_t               minor;
  logic                 steep;
  err_t                 minor2;
  err_t                 major2;

  // Stage register advances whenever it is empty or its beat moves on
  assign in_ready   = !fs_valid_r || push_ready;
  assign push_valid = fs_valid_r;

  // Signed deltas of the incoming beat
  assign dx_nxt = $signed({1'b0, in_item.end_x}) - $signed({1'b0, in_item.start_x});
  assign dy_nxt = $signed({1'b0, in_item.end_y}) - $signed({1'b0, in_item.start_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_valid_r <= 1'b0;
    end else if (in_ready) begin
      fs_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fs_action_r <= in_item.action;
      fs_x_r      <= in_item.start_x;
      fs_y_r      <= in_item.start_y;
      fs_dx_r     <= dx_nxt;
      fs_dy_r     <= dy_nxt;
    end
  end

  // Absolute deltas and major axis choice
  assign adx_w  = fs_dx_r[DW-1] ? DW'(-fs_dx_r) : DW'(fs_dx_r);
  assign ady_w  = fs_dy_r[DW-1] ? DW'(-fs_dy_r) : DW'(fs_dy_r);
  assign adx    = adx_w[COORD_BITS-1:0];
  assign ady    = ady_w[COORD_BITS-1:0];
  assign steep  = ady > adx;
  assign major  = steep ? ady : adx;
  assign minor  = steep ? adx : ady;
  assign minor2 = $signed({2'b00, minor, 1'b0});
  assign major2 = $signed({2'b00, major, 1'b0});

  always_comb begin
    push_cmd.is_load   = (fs_action_r == ACT_LOAD);
    push_cmd.start_x   = fs_x_r;
    push_cmd.start_y   = fs_y_r;
    push_cmd.major_len = major;
    push_cmd.dir_x     = (fs_dx_r == '0) ? DIR_HOLD : (fs_dx_r[DW-1] ? DIR_DEC : DIR_INC);
    push_cmd.dir_y     = (fs_dy_r == '0) ? DIR_HOLD : (fs_dy_r[DW-1] ? DIR_DEC : DIR_INC);
    push_cmd.swapped   = steep;
    push_cmd.err_init  = minor2 - $signed({3'b000, major});
    push_cmd.inc_minor = minor2;
    push_cmd.inc_diag  = minor2 - major2;
  end

endmodule

`default_nettype wire

### src/brl_queue.sv
// Short command queue between the front and back ends, register based.
// Uses brl_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module brl_queue #(
  parameter int DEPTH = brl_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire brl_pkg::cmd_t  push_cmd,
  output logic                pop_valid,
  input  wire logic           pop,
  output brl_pkg::cmd_t       pop_cmd
);
  import brl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### src/brl_back.sv
// Back end: holds the line state, runs one command a cycle while the output register
// is empty or draining, and keeps the result in that register. Uses brl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire brl_pkg::cmd_t  cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output brl_pkg::out_item_t  out_item
);
  import brl_pkg::*;

  coord_t    cur_x_r,   cur_x_nxt;
  coord_t    cur_y_r,   cur_y_nxt;
  err_t      err_r,     err_nxt;
  coord_t    rem_r,     rem_nxt;
  err_t      inc_min_r, inc_min_nxt;
  err_t      inc_dia_r, inc_dia_nxt;
  dir_t      dir_x_r,   dir_x_nxt;
  dir_t      dir_y_r,   dir_y_nxt;
  logic      swap_r,    swap_nxt;
  logic      busy_r,    busy_nxt;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r,     out_nxt;

  logic      slot_free;
  logic      err_pos;
  logic      emit;

  // Take a command whenever the output register is empty or draining
  assign slot_free = !out_vld_r || out_ready;
  assign cmd_pop   = cmd_valid && slot_free;
  assign emit      = cmd_pop && !cmd.is_load && busy_r;
  assign err_pos   = (err_r > 0);

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    err_nxt     = err_r;
    rem_nxt     = rem_r;
    inc_min_nxt = inc_min_r;
    inc_dia_nxt = inc_dia_r;
    dir_x_nxt   = dir_x_r;
    dir_y_nxt   = dir_y_r;
    swap_nxt    = swap_r;
    busy_nxt    = busy_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ready;

    if (cmd_pop && cmd.is_load) begin
      // New line: any line in progress is dropped
      cur_x_nxt   = cmd.start_x;
      cur_y_nxt   = cmd.start_y;
      err_nxt     = cmd.err_init;
      rem_nxt     = cmd.major_len;
      inc_min_nxt = cmd.inc_minor;
      inc_dia_nxt = cmd.inc_diag;
      dir_x_nxt   = cmd.dir_x;
      dir_y_nxt   = cmd.dir_y;
      swap_nxt    = cmd.swapped;
      busy_nxt    = (cmd.major_len != '0);
    end else if (emit) begin
      // Emit current pixel, then step along the line
      out_nxt.pixel_x    = cur_x_r;
      out_nxt.pixel_y    = cur_y_r;
      out_nxt.last_pixel = (rem_r == coord_t'(1));
      out_vld_nxt        = 1'b1;
      if (!swap_r || err_pos) begin
        cur_x_nxt = advance(cur_x_r, dir_x_r);
      end
      if (swap_r || err_pos) begin
        cur_y_nxt = advance(cur_y_r, dir_y_r);
      end
      err_nxt  = err_r + (err_pos ? inc_dia_r : inc_min_r);
      rem_nxt  = rem_r - coord_t'(1);
      busy_nxt = (rem_r != coord_t'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Line datapath and result payload
  always_ff @(posedge clk) begin
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    err_r     <= err_nxt;
    rem_r     <= rem_nxt;
    inc_min_r <= inc_min_nxt;
    inc_dia_r <= inc_dia_nxt;
    dir_x_r   <= dir_x_nxt;
    dir_y_r   <= dir_y_nxt;
    swap_r    <= swap_nxt;
    out_r     <= out_nxt;
  end

endmodule

`default_nettype wire

### src/bresenham_line_rasterizer_top.sv
// Top level of the Bresenham line rasteriser: front end, command queue, back end.
// Depends on brl_pkg, brl_front, brl_queue and brl_back.
//
//   port group   dir  handshake            beat payload
//   in_*         in   in_valid/in_ready    in_item_t  (load line / next pixel)
//   out_*        out  out_valid/out_ready  out_item_t (pixel and last flag)
//
// One beat is taken every cycle and one pixel leaves every cycle while out_ready
// stays high; a step beat's pixel passes through the front stage register, a queue
// entry and the output register before it is offered.
// Load beats and step beats with no line active use a back-end slot but give nothing.
// Reset is synchronous and active low; it clears the valid flags, queue pointers
// and the active-line flag.
// With out_ready low the output register holds, then the queue fills, then the
// front stage holds and in_ready falls.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer_top #(
  parameter int QUEUE_DEPTH = brl_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire brl_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output brl_pkg::out_item_t      out_item
);
  import brl_pkg::*;

  logic q_push_valid;
  logic q_push_ready;
  cmd_t q_push_cmd;
  logic q_pop_valid;
  logic q_pop;
  cmd_t q_pop_cmd;

  brl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  brl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_cmd    (q_pop_cmd)
  );

  brl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_pop_valid),
    .cmd       (q_pop_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // The back end only takes a command when its output register can take a result
  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_pop_valid && (!out_valid || out_ready)))
    else $error("command taken while the output register is blocked");

  // Input back-pressure only arises from a full queue
  a_stall_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (q_push_valid && !q_push_ready))
    else $error("input stalled with room in the queue");

  // A fresh result always follows a command taken in the cycle before
  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result appeared without a command");

  // Nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

### tb/tb_bresenham_line_rasterizer_top.sv
// Self-checking testbench for bresenham_line_rasterizer_top: directed table, then random lines.
// Expected pixels come from a line-walking predictor kept here; depends on brl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer_top;
  import brl_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_ITEMS = 1175;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  // How a table row gets its expected result
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_PIXEL
  } chk_e;

  typedef struct packed {
    chk_e      chk;
    in_item_t  beat;
    out_item_t px;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Line-walking state of the predictor
  coord_t ln_x, ln_y;
  int     ln_err;
  int     ln_left;
  int     ln_major, ln_minor;
  dir_t   ln_dir_x, ln_dir_y;
  bit     ln_steep;
  bit     ln_busy;

  out_item_t pixel_q[$];
  int        mismatches;
  int        cycles;
  bit        hold_req;
  int        quiet_left;
  row_t      dir_tab [DIR_ROWS];

  bresenham_line_rasterizer_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One unit along an axis, wrapping at the coordinate width
  function automatic coord_t walk(coord_t c, dir_t d);
    if (d == DIR_INC) return coord_t'(c + 1'b1);
    if (d == DIR_DEC) return coord_t'(c - 1'b1);
    return c;
  endfunction

  function automatic dir_t sign_of(int d);
    if (d > 0) return DIR_INC;
    if (d < 0) return DIR_DEC;
    return DIR_HOLD;
  endfunction

  // Apply one accepted beat to the predictor; returns 1 when a pixel comes out
  function automatic bit rasterise_beat(input in_item_t b, output out_item_t px);
    int dx;
    int dy;
    px = '0;
    if (b.action == ACT_LOAD) begin
      dx = int'(b.end_x) - int'(b.start_x);
      dy = int'(b.end_y) - int'(b.start_y);
      ln_dir_x = sign_of(dx);
      ln_dir_y = sign_of(dy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ln_steep = dy > dx;
      ln_major = ln_steep ? dy : dx;
      ln_minor = ln_steep ? dx : dy;
      ln_err   = 2 * ln_minor - ln_major;
      ln_x     = b.start_x;
      ln_y     = b.start_y;
      ln_left  = ln_major;
      ln_busy  = ln_left != 0;
      return 1'b0;
    end
    if (!ln_busy) return 1'b0;
    px.pixel_x    = ln_x;
    px.pixel_y    = ln_y;
    px.last_pixel = ln_left == 1;
    // minor axis moves on a positive decision term
    if (ln_err > 0) begin
      if (ln_steep) ln_x = walk(ln_x, ln_dir_x);
      else ln_y = walk(ln_y, ln_dir_y);
      ln_err -= 2 * ln_major;
    end
    if (ln_steep) ln_y = walk(ln_y, ln_dir_y);
    else ln_x = walk(ln_x, ln_dir_x);
    ln_err += 2 * ln_minor;
    ln_left--;
    ln_busy = ln_left != 0;
    return 1'b1;
  endfunction

  function automatic row_t ld(int sx, int sy, int ex, int ey);
    row_t r;
    r.chk          = CHK_NONE;
    r.beat.action  = ACT_LOAD;
    r.beat.start_x = coord_t'(sx);
    r.beat.start_y = coord_t'(sy);
    r.beat.end_x   = coord_t'(ex);
    r.beat.end_y   = coord_t'(ey);
    r.px           = '0;
    return r;
  endfunction

  function automatic row_t step_row(chk_e c, int x, int y, bit last);
    row_t r;
    r.chk           = c;
    r.beat          = '0;
    r.beat.action   = ACT_STEP;
    r.px.pixel_x    = coord_t'(x);
    r.px.pixel_y    = coord_t'(y);
    r.px.last_pixel = last;
    return r;
  endfunction

  // Sender idle time: mostly none or short, now and then long, with quiet runs
  function automatic int sender_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) quiet_left = $urandom_range(80, 20);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(25, 4);
  endfunction

  // Offer one beat from a falling edge, wait for the handshake, log the expectation
  task automatic send_beat(row_t r);
    int        gap;
    bit        got;
    out_item_t px;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r.beat;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    got = rasterise_beat(r.beat, px);
    case (r.chk)
      CHK_MODEL: if (got) pixel_q.push_back(px);
      CHK_PIXEL: pixel_q.push_back(r.px);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int r;
    int n;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          out_ready <= 1'b1;
          n = $urandom_range(40, 1);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          n = $urandom_range(3, 1);
        end else begin
          out_ready <= 1'b0;
          n = $urandom_range(30, 5);
        end
        repeat (n) @(negedge clk);
      end
    end
  end

  // Output check against the oldest expected pixel
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t ns: unexpected pixel, expected none actual x=%0d y=%0d last=%0d",
                 $time, out_item.pixel_x, out_item.pixel_y, out_item.last_pixel);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (out_item.pixel_x !== want.pixel_x) begin
          $display("%0t ns: pixel_x expected %0d actual %0d",
                   $time, want.pixel_x, out_item.pixel_x);
          mismatches++;
        end
        if (out_item.pixel_y !== want.pixel_y) begin
          $display("%0t ns: pixel_y expected %0d actual %0d",
                   $time, want.pixel_y, out_item.pixel_y);
          mismatches++;
        end
        if (out_item.last_pixel !== want.last_pixel) begin
          $display("%0t ns: last_pixel expected %0d actual %0d",
                   $time, want.last_pixel, out_item.last_pixel);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Main stimulus
  initial begin
    row_t        r;
    logic [63:0] rnd;
    int          counted;
    int          sx, sy, ex, ey;
    int          lo, hi;
    int          n;
    int          pick;
    bit          big;
    bit          hold_done;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    hold_req   = 1'b0;
    quiet_left = 0;
    mismatches = 0;
    ln_x = '0; ln_y = '0; ln_err = 0; ln_left = 0; ln_major = 0; ln_minor = 0;
    ln_dir_x = DIR_HOLD; ln_dir_y = DIR_HOLD; ln_steep = 1'b0; ln_busy = 1'b0;
    counted   = 0;
    hold_done = 1'b0;

    // Directed: idle step, zero length, extremes, abandoned lines, one-pixel line
    dir_tab = '{
      step_row(CHK_NONE, 0, 0, 0),
      ld(0, 0, 0, 0),
      step_row(CHK_NONE, 0, 0, 0),
      ld(0, 0, 1023, 1023),
      step_row(CHK_PIXEL, 0, 0, 0),
      step_row(CHK_PIXEL, 1, 1, 0),
      ld(1023, 0, 0, 1023),
      step_row(CHK_PIXEL, 1023, 0, 0),
      step_row(CHK_MODEL, 0, 0, 0),
      ld(5, 5, 6, 5),
      step_row(CHK_PIXEL, 5, 5, 1),
      step_row(CHK_NONE, 0, 0, 0),
      ld(1023, 1023, 0, 0),
      step_row(CHK_PIXEL, 1023, 1023, 0),
      step_row(CHK_MODEL, 0, 0, 0),
      ld(10, 10, 12, 20),
      step_row(CHK_MODEL, 0, 0, 0),
      step_row(CHK_MODEL, 0, 0, 0),
      step_row(CHK_MODEL, 0, 0, 0),
      ld(100, 50, 90, 47),
      step_row(CHK_MODEL, 0, 0, 0),
      step_row(CHK_MODEL, 0, 0, 0),
      step_row(CHK_MODEL, 0, 0, 0),
      ld(7, 7, 7, 0),
      step_row(CHK_PIXEL, 7, 7, 0)
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_beat(dir_tab[i]);

    // Random: mostly short lines walked to the end, some cut short or overrun,
    // a few long ones, and some noise beats
    while (counted < RANDOM_ITEMS) begin
      if (!hold_done && counted >= 400) begin
        hold_req   = 1'b1;
        hold_done  = 1'b1;
        quiet_left = 200;
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        rnd    = {$urandom, $urandom};
        r.beat = rnd[$bits(in_item_t)-1:0];
        r.chk  = CHK_MODEL;
        r.px   = '0;
        if (r.beat.action == ACT_LOAD || ln_busy) counted++;
        send_beat(r);
      end else begin
        big = $urandom_range(99) < 4;
        sx  = $urandom_range(1023);
        sy  = $urandom_range(1023);
        if (big) begin
          ex = $urandom_range(1023);
          ey = $urandom_range(1023);
        end else begin
          lo = (sx > 16) ? sx - 16 : 0;
          hi = (sx < 1007) ? sx + 16 : 1023;
          ex = $urandom_range(hi, lo);
          lo = (sy > 16) ? sy - 16 : 0;
          hi = (sy < 1007) ? sy + 16 : 1023;
          ey = $urandom_range(hi, lo);
        end
        send_beat(ld(sx, sy, ex, ey));
        counted++;
        if (big) begin
          n = $urandom_range(40, 1);
        end else begin
          pick = $urandom_range(99);
          if (pick < 80) n = ln_left;
          else if (pick < 90) n = ln_left + $urandom_range(2, 1);
          else n = $urandom_range(ln_left);
        end
        for (int k = 0; k < n; k++) begin
          rnd           = {$urandom, $urandom};
          r.beat        = rnd[$bits(in_item_t)-1:0];
          r.beat.action = ACT_STEP;
          r.chk         = CHK_MODEL;
          r.px          = '0;
          if (ln_busy) counted++;
          send_beat(r);
        end
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
